### hdl/qrs_pkg.sv
// shared widths, types and helper functions of the quadratic root solver
package qrs_pkg;

   // coefficient and root format
   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // square root chain: one result bit per cell
   localparam int SQ_STEPS = DATA_WIDTH;
   localparam int RES_W    = DATA_WIDTH;
   localparam int SREM_W   = DATA_WIDTH + 2;
   localparam int RAD_W    = 2 * DATA_WIDTH;
   localparam int ROOT_W   = DATA_WIDTH + 1;

   // numerator, denominator and divider chain
   localparam int NUM_W = DATA_WIDTH + 3;
   localparam int MAG_W = DATA_WIDTH + 2;
   localparam int DEN_W = DATA_WIDTH + 1;
   localparam int Q_W   = DATA_WIDTH + 1;
   localparam int N_W   = MAG_W + FRAC_BITS;
   localparam int DSH_W = DEN_W + Q_W - 1;

   typedef enum logic [2:0] {
      CASE_NO_REAL  = 3'd0,
      CASE_DOUBLE   = 3'd1,
      CASE_TWO      = 3'd2,
      CASE_LIN_ROOT = 3'd3,
      CASE_LIN_NONE = 3'd4,
      CASE_INFINITE = 3'd5
   } case_type;

   typedef struct packed {
      logic [SREM_W-1:0] rem;
      logic [RES_W-1:0]  res;
      logic [RAD_W-1:0]  rad;
   } sqrt_cell_type;

   typedef struct packed {
      logic [N_W-1:0]   rem;
      logic [DSH_W-1:0] dsh;
      logic [Q_W-1:0]   quo;
   } div_cell_type;

   typedef struct packed {
      case_type              code;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic [DATA_WIDTH-1:0] c;
      logic [1:0]            qr;
   } side_type;

   typedef struct packed {
      case_type         code;
      logic             neg_hi;
      logic             neg_lo;
      logic             big_hi;
      logic             big_lo;
      logic [DEN_W-1:0] ud;
   } ctl_type;

   // magnitude of a signed numerator
   function automatic logic [MAG_W-1:0] mag_num(input logic [NUM_W-1:0] v);
      logic [NUM_W-1:0] t;
      t = v[NUM_W-1] ? (NUM_W'(0) - v) : v;
      return t[MAG_W-1:0];
   endfunction

   // magnitude of a signed denominator
   function automatic logic [DEN_W-1:0] mag_den(input logic [DEN_W:0] v);
      logic [DEN_W:0] t;
      t = v[DEN_W] ? ((DEN_W + 1)'(0) - v) : v;
      return t[DEN_W-1:0];
   endfunction

   // round half away from zero, apply sign, saturate; returns {overflow, root}
   function automatic logic [DATA_WIDTH:0] finish_root(
      input logic [Q_W-1:0]   quo,
      input logic [N_W-1:0]   rem,
      input logic [DEN_W-1:0] ud,
      input logic             neg,
      input logic             big
   );
      logic           rnd;
      logic [Q_W:0]   qf;
      logic [Q_W:0]   neg_lim;
      logic [Q_W:0]   pos_lim;
      logic [DATA_WIDTH-1:0] mag;
      logic [DATA_WIDTH:0]   res;
      rnd     = {rem[DEN_W-1:0], 1'b0} >= {1'b0, ud};
      qf      = {1'b0, quo} + (Q_W + 1)'(rnd);
      neg_lim = (Q_W + 1)'(1) << (DATA_WIDTH - 1);
      pos_lim = neg_lim - (Q_W + 1)'(1);
      mag     = qf[DATA_WIDTH-1:0];
      if (neg) begin
         if (big || qf > neg_lim) begin
            res = {1'b1, 1'b1, {(DATA_WIDTH - 1){1'b0}}};
         end else begin
            res = {1'b0, DATA_WIDTH'(0) - mag};
         end
      end else begin
         if (big || qf > pos_lim) begin
            res = {1'b1, 1'b0, {(DATA_WIDTH - 1){1'b1}}};
         end else begin
            res = {1'b0, mag};
         end
      end
      return res;
   endfunction

endpackage

### hdl/qrs_sqrt_cell.sv
// one digit cell of the pipelined integer square root
module qrs_sqrt_cell
   import qrs_pkg::*;
(
   input  logic          clock,
   input  logic          en,
   input  sqrt_cell_type src_stage,
   output sqrt_cell_type dst_stage
);

   logic [SREM_W+1:0] cur;
   logic [SREM_W+1:0] trial;
   logic              fits;
   sqrt_cell_type     stage_in;
   sqrt_cell_type     stage_ff;

   // bring down two radicand bits and try the next result bit
   assign cur   = {src_stage.rem, src_stage.rad[RAD_W-1 -: 2]};
   assign trial = {2'b00, src_stage.res, 2'b01};
   assign fits  = cur >= trial;

   always_comb begin
      stage_in.rem = fits ? SREM_W'(cur - trial) : SREM_W'(cur);
      stage_in.res = {src_stage.res[RES_W-2:0], fits};
      stage_in.rad = {src_stage.rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign dst_stage = stage_ff;

endmodule

### hdl/qrs_div_cell.sv
// one quotient bit cell of the pipelined restoring divider
module qrs_div_cell
   import qrs_pkg::*;
(
   input  logic         clock,
   input  logic         en,
   input  div_cell_type src_stage,
   output div_cell_type dst_stage
);

   logic         fits;
   div_cell_type stage_in;
   div_cell_type stage_ff;

   // compare against the aligned divisor and subtract when it fits
   assign fits = DSH_W'(src_stage.rem) >= src_stage.dsh;

   always_comb begin
      stage_in.rem = fits ? (src_stage.rem - src_stage.dsh[N_W-1:0]) : src_stage.rem;
      stage_in.dsh = src_stage.dsh >> 1;
      stage_in.quo = {src_stage.quo[Q_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign dst_stage = stage_ff;

endmodule

### hdl/quadratic_root_solver.sv
// top level of the pipelined quadratic root solver
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/ready   | coef_a, coef_b, coef_c (signed Q16.16)
//   rsp     | out       | rsp_valid/ready   | case_code, root_high, root_low, overflow
//
// one equation enters per cycle while the pipeline is not held; it passes the capture,
// multiply and classify stages, 32 square root cells, the numerator and divider setup
// stages, 33 divider cells and the output register.
// the whole pipeline advances together; it holds while a result waits
// at the output and the next stage cannot move.
// synchronous reset clears only the valid bits; the data registers are not reset.
module quadratic_root_solver
   import qrs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_coef_a,
   input  logic signed [DATA_WIDTH-1:0] req_coef_b,
   input  logic signed [DATA_WIDTH-1:0] req_coef_c,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_case_code,
   output logic signed [DATA_WIDTH-1:0] rsp_root_high,
   output logic signed [DATA_WIDTH-1:0] rsp_root_low,
   output logic                         rsp_overflow
);

   logic en;

   // capture stage
   logic                  v0_ff;
   logic [DATA_WIDTH-1:0] a0_ff, b0_ff, c0_ff;

   // multiply stage
   logic signed [RAD_W-1:0] bb;
   logic signed [RAD_W-1:0] ac;
   logic                    v1_ff;
   logic [RAD_W-1:0]        bb1_ff, ac1_ff;
   logic [DATA_WIDTH-1:0]   a1_ff, b1_ff, c1_ff;

   // classify stage
   logic signed [RAD_W:0] e_wide;
   case_type              code2;
   logic                  v2_ff;
   side_type              side2_ff;
   logic [RAD_W-1:0]      rad2_ff;

   // square root chain
   sqrt_cell_type sq_src;
   sqrt_cell_type sq_dst [SQ_STEPS];
   side_type      side_sq_ff [SQ_STEPS];
   logic          vsq_ff [SQ_STEPS];

   // root and numerator stage
   logic [RES_W-1:0]  s_fin;
   logic [SREM_W-1:0] r_fin;
   logic              up;
   logic [ROOT_W-1:0] root;
   logic              lin;
   logic [NUM_W-1:0]  negb, negc, root_x;
   logic [NUM_W-1:0]  num_hi, num_lo;
   logic [DEN_W:0]    den;
   side_type          side_l;
   logic              v3_ff;
   case_type          code3_ff;
   logic [NUM_W-1:0]  num_hi3_ff, num_lo3_ff;
   logic [DEN_W:0]    den3_ff;

   // divider setup stage
   logic [MAG_W-1:0] un_hi, un_lo;
   logic [N_W-1:0]   nn_hi, nn_lo;
   logic [DEN_W-1:0] ud;
   ctl_type          ctl4;
   div_cell_type     dv_hi4, dv_lo4;
   logic             v4_ff;
   ctl_type          ctl4_ff;
   div_cell_type     dv_hi4_ff, dv_lo4_ff;

   // divider chains
   div_cell_type dv_hi_dst [Q_W];
   div_cell_type dv_lo_dst [Q_W];
   ctl_type      ctl_dv_ff [Q_W];
   logic         vdv_ff [Q_W];

   // output stage
   ctl_type               ctl_l;
   logic [DATA_WIDTH:0]   fin_hi, fin_lo;
   logic [2:0]            code_out;
   logic [DATA_WIDTH-1:0] hi_out, lo_out;
   logic                  ovf_out;
   logic                  rsp_valid_ff;
   logic [2:0]            rsp_code_ff;
   logic [DATA_WIDTH-1:0] rsp_hi_ff, rsp_lo_ff;
   logic                  rsp_ovf_ff;

   // the pipeline moves whenever the output register can take a result
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // capture the coefficients of each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff <= req_coef_a;
         b0_ff <= req_coef_b;
         c0_ff <= req_coef_c;
      end
   end

   // b squared and a times c
   assign bb = $signed(b0_ff) * $signed(b0_ff);
   assign ac = $signed(a0_ff) * $signed(c0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bb1_ff <= bb;
         ac1_ff <= ac;
         a1_ff  <= a0_ff;
         b1_ff  <= b0_ff;
         c1_ff  <= c0_ff;
      end
   end

   // quarter discriminant and case selection
   assign e_wide = $signed({3'b000, bb1_ff[RAD_W-1:2]}) - $signed({ac1_ff[RAD_W-1], ac1_ff});

   always_comb begin
      if (a1_ff == '0) begin
         if (b1_ff == '0 && c1_ff == '0) begin
            code2 = CASE_INFINITE;
         end else if (b1_ff == '0) begin
            code2 = CASE_LIN_NONE;
         end else begin
            code2 = CASE_LIN_ROOT;
         end
      end else if (e_wide[RAD_W]) begin
         code2 = CASE_NO_REAL;
      end else if (e_wide == '0 && bb1_ff[1:0] == 2'b00) begin
         code2 = CASE_DOUBLE;
      end else begin
         code2 = CASE_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff.code <= code2;
         side2_ff.a    <= a1_ff;
         side2_ff.b    <= b1_ff;
         side2_ff.c    <= c1_ff;
         side2_ff.qr   <= bb1_ff[1:0];
         rad2_ff       <= e_wide[RAD_W] ? '0 : e_wide[RAD_W-1:0];
      end
   end

   // square root cells, one result bit each
   always_comb begin
      sq_src.rem = '0;
      sq_src.res = '0;
      sq_src.rad = rad2_ff;
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
      if (k == 0) begin : g_first
         qrs_sqrt_cell u_cell (
            .clock     (clock),
            .en        (en),
            .src_stage (sq_src),
            .dst_stage (sq_dst[k])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               side_sq_ff[k] <= side2_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vsq_ff[k] <= 1'b0;
            end else if (en) begin
               vsq_ff[k] <= v2_ff;
            end
         end
      end else begin : g_rest
         qrs_sqrt_cell u_cell (
            .clock     (clock),
            .en        (en),
            .src_stage (sq_dst[k-1]),
            .dst_stage (sq_dst[k])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               side_sq_ff[k] <= side_sq_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vsq_ff[k] <= 1'b0;
            end else if (en) begin
               vsq_ff[k] <= vsq_ff[k-1];
            end
         end
      end
   end

   // rounded square root of the full discriminant and the numerators
   assign s_fin  = sq_dst[SQ_STEPS-1].res;
   assign r_fin  = sq_dst[SQ_STEPS-1].rem;
   assign side_l = side_sq_ff[SQ_STEPS-1];
   assign up     = {r_fin, side_l.qr} >= {2'b00, s_fin, 2'b01};
   assign root   = {s_fin, 1'b0} + ROOT_W'(up);
   assign lin    = side_l.code == CASE_LIN_ROOT || side_l.code == CASE_LIN_NONE ||
                   side_l.code == CASE_INFINITE;
   assign negb   = NUM_W'(0) - {{3{side_l.b[DATA_WIDTH-1]}}, side_l.b};
   assign negc   = NUM_W'(0) - {{3{side_l.c[DATA_WIDTH-1]}}, side_l.c};
   assign root_x = {2'b00, root};
   assign num_hi = lin ? negc : (negb + root_x);
   assign num_lo = negb - root_x;

   always_comb begin
      if (side_l.code == CASE_LIN_NONE || side_l.code == CASE_INFINITE) begin
         den = (DEN_W + 1)'(1);
      end else if (lin) begin
         den = {{2{side_l.b[DATA_WIDTH-1]}}, side_l.b};
      end else begin
         den = {side_l.a[DATA_WIDTH-1], side_l.a, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= vsq_ff[SQ_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code3_ff   <= side_l.code;
         num_hi3_ff <= num_hi;
         num_lo3_ff <= num_lo;
         den3_ff    <= den;
      end
   end

   // magnitudes, signs and early overflow detection for both dividers
   assign un_hi = mag_num(num_hi3_ff);
   assign un_lo = mag_num(num_lo3_ff);
   assign ud    = mag_den(den3_ff);
   assign nn_hi = {un_hi, {FRAC_BITS{1'b0}}};
   assign nn_lo = {un_lo, {FRAC_BITS{1'b0}}};

   always_comb begin
      ctl4.code   = code3_ff;
      ctl4.neg_hi = num_hi3_ff[NUM_W-1] ^ den3_ff[DEN_W];
      ctl4.neg_lo = num_lo3_ff[NUM_W-1] ^ den3_ff[DEN_W];
      ctl4.big_hi = DEN_W'(nn_hi[N_W-1:Q_W]) >= ud;
      ctl4.big_lo = DEN_W'(nn_lo[N_W-1:Q_W]) >= ud;
      ctl4.ud     = ud;
      dv_hi4.rem  = nn_hi;
      dv_hi4.dsh  = {ud, {(Q_W - 1){1'b0}}};
      dv_hi4.quo  = '0;
      dv_lo4.rem  = nn_lo;
      dv_lo4.dsh  = {ud, {(Q_W - 1){1'b0}}};
      dv_lo4.quo  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl4_ff   <= ctl4;
         dv_hi4_ff <= dv_hi4;
         dv_lo4_ff <= dv_lo4;
      end
   end

   // divider cells, one quotient bit each, two lanes
   for (genvar k = 0; k < Q_W; k++) begin : g_dv
      if (k == 0) begin : g_first
         qrs_div_cell u_hi (
            .clock     (clock),
            .en        (en),
            .src_stage (dv_hi4_ff),
            .dst_stage (dv_hi_dst[k])
         );
         qrs_div_cell u_lo (
            .clock     (clock),
            .en        (en),
            .src_stage (dv_lo4_ff),
            .dst_stage (dv_lo_dst[k])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               ctl_dv_ff[k] <= ctl4_ff;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vdv_ff[k] <= 1'b0;
            end else if (en) begin
               vdv_ff[k] <= v4_ff;
            end
         end
      end else begin : g_rest
         qrs_div_cell u_hi (
            .clock     (clock),
            .en        (en),
            .src_stage (dv_hi_dst[k-1]),
            .dst_stage (dv_hi_dst[k])
         );
         qrs_div_cell u_lo (
            .clock     (clock),
            .en        (en),
            .src_stage (dv_lo_dst[k-1]),
            .dst_stage (dv_lo_dst[k])
         );
         always_ff @(posedge clock) begin
            if (en) begin
               ctl_dv_ff[k] <= ctl_dv_ff[k-1];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vdv_ff[k] <= 1'b0;
            end else if (en) begin
               vdv_ff[k] <= vdv_ff[k-1];
            end
         end
      end
   end

   // rounding, saturation and result selection
   assign ctl_l  = ctl_dv_ff[Q_W-1];
   assign fin_hi = finish_root(dv_hi_dst[Q_W-1].quo, dv_hi_dst[Q_W-1].rem, ctl_l.ud,
                               ctl_l.neg_hi, ctl_l.big_hi);
   assign fin_lo = finish_root(dv_lo_dst[Q_W-1].quo, dv_lo_dst[Q_W-1].rem, ctl_l.ud,
                               ctl_l.neg_lo, ctl_l.big_lo);

   always_comb begin
      code_out = ctl_l.code;
      unique case (ctl_l.code)
         CASE_DOUBLE, CASE_TWO: begin
            hi_out  = fin_hi[DATA_WIDTH-1:0];
            lo_out  = fin_lo[DATA_WIDTH-1:0];
            ovf_out = fin_hi[DATA_WIDTH] | fin_lo[DATA_WIDTH];
         end
         CASE_LIN_ROOT: begin
            hi_out  = fin_hi[DATA_WIDTH-1:0];
            lo_out  = '0;
            ovf_out = fin_hi[DATA_WIDTH];
         end
         default: begin
            hi_out  = '0;
            lo_out  = '0;
            ovf_out = 1'b0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vdv_ff[Q_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_code_ff <= code_out;
         rsp_hi_ff   <= hi_out;
         rsp_lo_ff   <= lo_out;
         rsp_ovf_ff  <= ovf_out;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_case_code = rsp_code_ff;
   assign rsp_root_high = rsp_hi_ff;
   assign rsp_root_low  = rsp_lo_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   // cases without roots report zeros and no overflow
   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_case_code == CASE_NO_REAL || rsp_case_code == CASE_LIN_NONE ||
                    rsp_case_code == CASE_INFINITE)
      |-> rsp_root_high == '0 && rsp_root_low == '0 && !rsp_overflow)
      else $error("root or overflow set for a case without roots");

   // linear case leaves the second root at zero
   a_lin_low_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_code == CASE_LIN_ROOT |-> rsp_root_low == '0)
      else $error("second root nonzero in linear case");

   // a double root gives equal roots
   a_double_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_code == CASE_DOUBLE |-> rsp_root_high == rsp_root_low)
      else $error("double root halves differ");

   // square root remainder stays below 2s+1
   a_sqrt_rem: assert property (@(posedge clock) disable iff (reset)
      vsq_ff[SQ_STEPS-1] |-> r_fin <= {1'b0, s_fin, 1'b0})
      else $error("square root remainder out of range");

   // an accepted transfer enters the pipeline
   a_accept_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v0_ff)
      else $error("accepted transfer lost at capture stage");

endmodule

### verif/quadratic_root_solver_check.sv
// checker of the quadratic root solver: predicts roots and compares results
module quadratic_root_solver_check
   import qrs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_coef_a,
   input  logic signed [DATA_WIDTH-1:0] req_coef_b,
   input  logic signed [DATA_WIDTH-1:0] req_coef_c,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [2:0]                   rsp_case_code,
   input  logic signed [DATA_WIDTH-1:0] rsp_root_high,
   input  logic signed [DATA_WIDTH-1:0] rsp_root_low,
   input  logic                         rsp_overflow,
   output int                           fail_count,
   output int                           roots_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      case_type                code;
      logic [DATA_WIDTH-1:0]   hi;
      logic [DATA_WIDTH-1:0]   lo;
      logic                    ovf;
   } roots_type;

   roots_type roots_q[$];

   // num * 2^FRAC_BITS / den, round half away from zero, saturate
   function automatic longint scaled_quotient(input longint num, input longint den,
                                              inout logic ovf);
      logic             neg;
      logic             big;
      logic [63:0]      un;
      logic [63:0]      ud;
      logic [63:0]      q;
      logic [63:0]      rem;
      logic [63:0]      neg_lim;
      logic [63:0]      pos_lim;
      logic             bitv;
      neg = (num < 0) != (den < 0);
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      q = un / ud;
      rem = un % ud;
      big = 1'b0;
      neg_lim = 64'd1 << (DATA_WIDTH - 1);
      pos_lim = neg_lim - 1;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         bitv = 1'b0;
         if (rem >= ud) begin
            rem = rem - ud;
            bitv = 1'b1;
         end
         if (q > (64'd1 << 61)) big = 1'b1;
         else q = (q << 1) | 64'(bitv);
      end
      if (!big && (rem << 1) >= ud) q = q + 1;
      if (neg) begin
         if (big || q > neg_lim) begin
            ovf = 1'b1;
            return -longint'(neg_lim);
         end
         return -longint'(q);
      end
      if (big || q > pos_lim) begin
         ovf = 1'b1;
         return longint'(pos_lim);
      end
      return longint'(q);
   endfunction

   // integer square root of a 64-bit value
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic roots_type solve_equation(input longint a, input longint b,
                                                input longint c);
      roots_type   r;
      logic        ovf;
      longint      hi;
      longint      lo;
      logic [63:0] sq;
      longint      e;
      logic [63:0] qr;
      logic [63:0] s;
      logic [63:0] rm;
      longint      root;
      ovf = 1'b0;
      hi = 0;
      lo = 0;
      if (a == 0) begin
         if (b == 0 && c == 0) r.code = CASE_INFINITE;
         else if (b == 0) r.code = CASE_LIN_NONE;
         else begin
            r.code = CASE_LIN_ROOT;
            hi = scaled_quotient(-c, b, ovf);
         end
      end else begin
         sq = b * b;
         e = longint'(sq >> 2) - a * c;
         qr = sq & 64'd3;
         if (e < 0) r.code = CASE_NO_REAL;
         else if (e == 0 && qr == 0) begin
            r.code = CASE_DOUBLE;
            hi = scaled_quotient(-b, 2 * a, ovf);
            lo = hi;
         end else begin
            s = floor_sqrt(e);
            rm = e - s * s;
            root = 2 * s;
            if (4 * rm + qr >= 4 * s + 1) root = root + 1;
            r.code = CASE_TWO;
            hi = scaled_quotient(-b + root, 2 * a, ovf);
            lo = scaled_quotient(-b - root, 2 * a, ovf);
         end
      end
      r.hi = hi[DATA_WIDTH-1:0];
      r.lo = lo[DATA_WIDTH-1:0];
      r.ovf = ovf;
      return r;
   endfunction

   // predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      roots_type want;
      int        errs;
      errs = 0;
      if (reset) begin
         roots_q.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            roots_q.push_back(solve_equation(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_valid && rsp_ready) begin
            if (roots_q.size() == 0) begin
               $error("response with nothing expected");
               errs = errs + 1;
            end else begin
               want = roots_q.pop_front();
               if (rsp_case_code != want.code) begin
                  $error("case_code expected %0d actual %0d", want.code, rsp_case_code);
                  errs = errs + 1;
               end
               if (rsp_root_high != want.hi) begin
                  $error("root_high expected %h actual %h", want.hi, rsp_root_high);
                  errs = errs + 1;
               end
               if (rsp_root_low != want.lo) begin
                  $error("root_low expected %h actual %h", want.lo, rsp_root_low);
                  errs = errs + 1;
               end
               if (rsp_overflow != want.ovf) begin
                  $error("overflow expected %0d actual %0d", want.ovf, rsp_overflow);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
      roots_pending = roots_q.size();
   end
endmodule

### verif/quadratic_root_solver_test.sv
// testbench top of the quadratic root solver: stimulus and verdict
module quadratic_root_solver_test
   import qrs_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_LIMIT   = 5000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [DATA_WIDTH-1:0] req_coef_a = '0;
   logic signed [DATA_WIDTH-1:0] req_coef_b = '0;
   logic signed [DATA_WIDTH-1:0] req_coef_c = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [2:0]                   rsp_case_code;
   logic signed [DATA_WIDTH-1:0] rsp_root_high;
   logic signed [DATA_WIDTH-1:0] rsp_root_low;
   logic                         rsp_overflow;
   int                           fail_count;
   int                           roots_pending;
   int                           idle_cycles = 0;
   logic                         sending_done = 1'b0;

   always #1 clock = ~clock;

   quadratic_root_solver i_dut (.*);

   quadratic_root_solver_check i_check (.*);

   // random gap length: mostly short, a few long
   function automatic int gap_length();
      if ($urandom_range(9) < 7) return $urandom_range(1) ? 0 : 1;
      if ($urandom_range(9) < 8) return $urandom_range(5, 2);
      return $urandom_range(40, 10);
   endfunction

   // coefficient value, biased toward small and edge values
   function automatic logic [31:0] coef_value();
      case ($urandom_range(7))
         0: return 32'sh8000_0000 + $urandom_range(3);
         1: return 32'sh7fff_ffff - $urandom_range(3);
         2: return 32'($signed($urandom_range(8)) - 4) << 16;
         3: return 32'($signed($urandom_range(200)) - 100);
         4: return 32'($signed($urandom_range(20000)) - 10000) << $urandom_range(12, 2);
         default: return $urandom();
      endcase
   endfunction

   // valid drops only when a gap follows, so back to back transfers keep it high
   task automatic send_equation(input logic [31:0] a, input logic [31:0] b,
                                input logic [31:0] c);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // receiver: random stalls and one long hold-off
   initial begin
      int stall;
      @(negedge reset);
      repeat (300) begin
         rsp_ready <= $urandom_range(1);
         @(posedge clock);
      end
      rsp_ready <= 1'b0;
      repeat (200) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(3) == 0) begin
            stall = gap_length();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end else if ($urandom_range(30) == 0) begin
            repeat (100) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // linear forms: infinite, none, root, overflowing root
      send_equation(0, 0, 0);
      send_equation(0, 0, 32'h0001_0000);
      send_equation(0, 32'h0002_0000, 32'h0003_0000);
      send_equation(0, 1, 32'h7fff_ffff);
      send_equation(0, 32'hffff_ffff, 32'h8000_0000);
      // double roots, no real roots, two roots
      send_equation(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000);
      send_equation(32'h0001_0000, 0, 32'h0001_0000);
      send_equation(32'h0001_0000, 0, 32'hffff_0000);
      send_equation(32'hffff_0000, 32'h0003_0000, 32'h0001_0000);
      send_equation(1, 32'h7fff_ffff, 0);
      send_equation(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_equation(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_equation(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      send_equation(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
      send_equation(32'h0000_0004, 32'h0000_0004, 32'h0000_0001);
      send_equation(32'h0000_0001, 32'h0000_0003, 32'h0000_0001);
      send_equation(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      // random equations; some built from chosen roots
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         a = coef_value();
         b = coef_value();
         c = coef_value();
         case ($urandom_range(9))
            0: a = 0;
            1: begin a = 0; b = 0; end
            2: c = 0;
            3: begin
               a = 32'($signed($urandom_range(64)) - 32);
               b = 2 * $signed(a) * ($signed($urandom_range(64)) - 32);
               c = ($signed(b) / 2) * ($signed(b) / 2) / ((a == 0) ? 1 : $signed(a));
            end
            default: ;
         endcase
         send_equation(a, b, c);
      end
      req_valid <= 1'b0;
      sending_done <= 1'b1;
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("quadratic_root_solver: mismatch");
         $finish;
      end
   end

   initial begin
      @(posedge sending_done);
      while (roots_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0 && roots_pending == 0) begin
         $display("quadratic_root_solver: match");
      end else begin
         $display("quadratic_root_solver: mismatch");
      end
      $finish;
   end
endmodule
